// ===== hw/rtl/gfli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfli_pkg;

   localparam int SAMPLE_BITS = 16;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   sample_valid;
      logic                   series_end;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] value;
      logic                   value_valid;
      logic                   was_filled;
      logic                   gap_overflow;
      logic                   run_last;
      logic                   stream_end;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gap_fill_linear_interpolator.sv =====
// Latency: a missing sample that is only counted gives no result and frees the input next cycle.
// Each interpolated result passes S_NEXT, S_LOAD, S_DIV (restoring divider, one quotient bit
// per cycle), S_FIX and S_PUT; an original, back-filled or held result passes S_NEXT and S_PUT.
// Flow: one item at a time; S_PUT waits on output stalls; a full interior gap of 63 gives 63 fills.
// Reset (synchronous, active high) clears the gap count, hold flags and output valid.
`timescale 1ns / 1ps
`default_nettype none

module gap_fill_linear_interpolator #(
   parameter int MAX_GAP = 63
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  gfli_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output gfli_pkg::rsp_type  rsp_data
);

   localparam int SB     = gfli_pkg::SAMPLE_BITS;
   localparam int PEND_W = $clog2(MAX_GAP + 1);
   localparam int CNT_W  = $clog2(MAX_GAP + 2);
   localparam int Q      = SB + 1;          // quotient bits, |q| <= |x1 - x0|
   localparam int NUM_W  = Q + CNT_W;       // signed numerator (x1 - x0) * k
   localparam int DC_W   = $clog2(Q);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NEXT = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIX  = 3'd4;
   localparam logic [2:0] S_PUT  = 3'd5;

   localparam logic [1:0] K_INTERP = 2'd0;
   localparam logic [1:0] K_CONST  = 2'd1;
   localparam logic [1:0] K_HELD   = 2'd2;

   // series state
   logic [SB-1:0]     last_good_ff, last_good_in;
   logic              have_good_ff, have_good_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              ovh_ff, ovh_in;

   // per-item work
   logic [2:0]        state_ff, state_in;
   logic [SB-1:0]     x_ff, x_in;
   logic [SB-1:0]     base_ff, base_in;
   logic              have_ff, have_in;
   logic              end_ff, end_in;
   logic              orig_ff, orig_in;
   logic              ovf_ff, ovf_in;
   logic [1:0]        kind_ff, kind_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  span_ff, span_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [Q-1:0]      quo_ff, quo_in;
   logic [DC_W-1:0]   dcnt_ff, dcnt_in;
   gfli_pkg::rsp_type pend_rsp_ff, pend_rsp_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   gfli_pkg::rsp_type rsp_ff, rsp_in;

   logic [Q-1:0]      diff_w;
   logic [NUM_W-1:0]  diff_ext;
   logic [NUM_W-1:0]  mag_w;
   logic [CNT_W:0]    trial_w;
   logic              trial_ge;
   logic [CNT_W:0]    trial_sub;
   logic [Q:0]        quo_ext;
   logic [Q:0]        quo_sgn;
   logic [Q:0]        base_ext;
   logic [Q:0]        fill_sum;
   logic              fill_last;
   logic              req_xfer;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign diff_w    = {x_ff[SB-1], x_ff} - {base_ff[SB-1], base_ff};
   assign diff_ext  = {{(NUM_W-Q){diff_w[Q-1]}}, diff_w};
   assign mag_w     = num_ff[NUM_W-1] ? (~num_ff + NUM_W'(1)) : num_ff;
   assign trial_w   = {rem_ff, quo_ff[Q-1]};
   assign trial_ge  = (trial_w >= {1'b0, span_ff});
   assign trial_sub = trial_w - {1'b0, span_ff};
   assign quo_ext   = {1'b0, quo_ff};
   assign quo_sgn   = neg_ff ? (~quo_ext + (Q+1)'(1)) : quo_ext;
   assign base_ext  = {{(Q+1-SB){base_ff[SB-1]}}, base_ff};
   assign fill_sum  = base_ext + quo_sgn;
   assign fill_last = (cnt_ff == CNT_W'(1)) && !orig_ff;

   always_comb begin
      last_good_in = last_good_ff;
      have_good_in = have_good_ff;
      pend_in      = pend_ff;
      ovh_in       = ovh_ff;
      state_in     = state_ff;
      x_in         = x_ff;
      base_in      = base_ff;
      have_in      = have_ff;
      end_in       = end_ff;
      orig_in      = orig_ff;
      ovf_in       = ovf_ff;
      kind_in      = kind_ff;
      cnt_in       = cnt_ff;
      span_in      = span_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      pend_rsp_in  = pend_rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               x_in    = req_data.sample;
               base_in = last_good_ff;
               have_in = have_good_ff;
               end_in  = req_data.series_end;
               num_in  = '0;
               span_in = CNT_W'(pend_ff) + CNT_W'(1);
               orig_in = 1'b0;
               ovf_in  = 1'b0;
               kind_in = K_HELD;
               cnt_in  = '0;
               if (req_data.sample_valid) begin
                  cnt_in       = (!ovh_ff) ? CNT_W'(pend_ff) : '0;
                  kind_in      = have_good_ff ? K_INTERP : K_CONST;
                  orig_in      = 1'b1;
                  last_good_in = req_data.sample;
                  have_good_in = 1'b1;
                  pend_in      = '0;
                  ovh_in       = 1'b0;
                  state_in     = S_NEXT;
               end else if (ovh_ff) begin
                  cnt_in   = CNT_W'(1);
                  ovf_in   = 1'b1;
                  state_in = S_NEXT;
               end else if (pend_ff >= PEND_W'(MAX_GAP)) begin
                  // gap too long: release everything held at the last good value
                  cnt_in   = CNT_W'(pend_ff) + CNT_W'(1);
                  ovf_in   = 1'b1;
                  pend_in  = '0;
                  ovh_in   = 1'b1;
                  state_in = S_NEXT;
               end else if (req_data.series_end) begin
                  cnt_in   = CNT_W'(pend_ff) + CNT_W'(1);
                  pend_in  = '0;
                  state_in = S_NEXT;
               end else begin
                  pend_in = pend_ff + PEND_W'(1);
               end
               if (req_data.series_end) begin
                  last_good_in = '0;
                  have_good_in = 1'b0;
                  pend_in      = '0;
                  ovh_in       = 1'b0;
               end
            end
         end
         S_NEXT: begin
            pend_rsp_in.gap_overflow = ovf_ff;
            if (cnt_ff != '0) begin
               pend_rsp_in.run_last   = fill_last;
               pend_rsp_in.stream_end = fill_last && end_ff;
               cnt_in                 = cnt_ff - CNT_W'(1);
               if (kind_ff == K_INTERP) begin
                  num_in   = num_ff + diff_ext;
                  state_in = S_LOAD;
               end else if (kind_ff == K_CONST) begin
                  pend_rsp_in.value       = x_ff;
                  pend_rsp_in.value_valid = 1'b1;
                  pend_rsp_in.was_filled  = 1'b1;
                  state_in                = S_PUT;
               end else begin
                  pend_rsp_in.value       = have_ff ? base_ff : '0;
                  pend_rsp_in.value_valid = have_ff;
                  pend_rsp_in.was_filled  = have_ff;
                  state_in                = S_PUT;
               end
            end else begin
               pend_rsp_in.value        = x_ff;
               pend_rsp_in.value_valid  = 1'b1;
               pend_rsp_in.was_filled   = 1'b0;
               pend_rsp_in.gap_overflow = 1'b0;
               pend_rsp_in.run_last     = 1'b1;
               pend_rsp_in.stream_end   = end_ff;
               orig_in                  = 1'b0;
               state_in                 = S_PUT;
            end
         end
         S_LOAD: begin
            // the high part of |num| is already below span
            neg_in   = num_ff[NUM_W-1];
            rem_in   = mag_w[NUM_W-1:Q];
            quo_in   = mag_w[Q-1:0];
            dcnt_in  = DC_W'(Q - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial_sub[CNT_W-1:0] : trial_w[CNT_W-1:0];
            quo_in  = {quo_ff[Q-2:0], trial_ge};
            dcnt_in = dcnt_ff - DC_W'(1);
            if (dcnt_ff == '0) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            pend_rsp_in.value       = fill_sum[SB-1:0];
            pend_rsp_in.value_valid = 1'b1;
            pend_rsp_in.was_filled  = 1'b1;
            state_in                = S_PUT;
         end
         S_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_rsp_ff;
               state_in     = pend_rsp_ff.run_last ? S_IDLE : S_NEXT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_good_ff <= '0;
         have_good_ff <= 1'b0;
         pend_ff      <= '0;
         ovh_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_good_ff <= last_good_in;
         have_good_ff <= have_good_in;
         pend_ff      <= pend_in;
         ovh_ff       <= ovh_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      base_ff     <= base_in;
      have_ff     <= have_in;
      end_ff      <= end_in;
      orig_ff     <= orig_in;
      ovf_ff      <= ovf_in;
      kind_ff     <= kind_in;
      cnt_ff      <= cnt_in;
      span_ff     <= span_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      pend_rsp_ff <= pend_rsp_in;
      rsp_ff      <= rsp_in;
   end

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder not below span");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_W'(MAX_GAP))
      else $error("gap count above limit");

   a_hold_no_pend: assert property (@(posedge clock) disable iff (reset)
      ovh_ff |-> (pend_ff == '0))
      else $error("overflow hold with gap count");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stream_end |-> rsp_ff.run_last)
      else $error("series end on a result that is not last of its item");

   a_put_after_fix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIX) |=> (state_ff == S_PUT) && pend_rsp_ff.was_filled)
      else $error("interpolated result not staged");

endmodule

`default_nettype wire
